[rtl/core/encoder_speed_pi_controller_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the encoder speed PI controller
// Clocked implication checks with a synchronous reset that disables them.
// ----------------------------------------------------------------------------
`ifndef ENCODER_SPEED_PI_CONTROLLER_ASSERT_SVH
`define ENCODER_SPEED_PI_CONTROLLER_ASSERT_SVH

// Same-cycle implication
`define ESPC_ASSERT_IMPLY(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("espc check failed: same-cycle implication");

// Next-cycle implication
`define ESPC_ASSERT_NEXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("espc check failed: next-cycle implication");

`endif

[rtl/core/espc_pkg.sv]
// ----------------------------------------------------------------------------
// espc_pkg
// Widths, constants, register map and command types of the speed controller.
// ----------------------------------------------------------------------------
`default_nettype none

package espc_pkg;

  // Integral accumulator width and the widths that follow from it
  localparam int INTEGRAL_WIDTH = 40;
  localparam int OP_W     = (INTEGRAL_WIDTH < 47) ? INTEGRAL_WIDTH : 47;
  localparam int OP_HI_W  = OP_W - 24;
  localparam int TOTAL_W  = OP_W + 18;
  localparam int OPX_W    = (INTEGRAL_WIDTH + 1 > 48) ? INTEGRAL_WIDTH + 1 : 48;

  // Field widths
  localparam int PULSE_W  = 16;
  localparam int TARGET_W = 16;
  localparam int DRIVE_W  = 16;
  localparam int SPEED_W  = 24;
  localparam int ERR_W    = 25;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 17;

  // Shared multiplier
  localparam int MUL_A_W = 18;
  localparam int MUL_B_W = 26;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;

  localparam logic [16:0] ALPHA_ONE = 17'd65536;

  localparam logic signed [36:0] SPD_MAX_X = 37'sd8388607;
  localparam logic signed [36:0] SPD_MIN_X = -37'sd8388608;

  localparam logic signed [INTEGRAL_WIDTH:0] INTEG_MAX_X =
    {2'b00, {(INTEGRAL_WIDTH - 1){1'b1}}};
  localparam logic signed [INTEGRAL_WIDTH:0] INTEG_MIN_X =
    {2'b11, {(INTEGRAL_WIDTH - 1){1'b0}}};

  localparam logic signed [OPX_W-1:0] OP_MAX_X = OPX_W'(64'sd70368744177663);
  localparam logic signed [OPX_W-1:0] OP_MIN_X = -OP_MAX_X;

  // Register map
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DIR   = 3'd0,
    REG_RPP   = 3'd1,
    REG_ALPHA = 3'd2,
    REG_KP    = 3'd3,
    REG_KI    = 3'd4,
    REG_LIMIT = 3'd5,
    REG_RAMP  = 3'd6
  } cfg_idx_t;

  typedef struct packed {
    logic        dir;
    logic [15:0] rpp;
    logic [16:0] alpha;
    logic [15:0] kp;
    logic [15:0] ki;
    logic [14:0] limit;
    logic [14:0] ramp;
  } cfg_t;

  // Controller states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SPEED,
    ST_RAW,
    ST_FILT_NEW,
    ST_FILT_OLD,
    ST_FILT_SUM,
    ST_ERR,
    ST_INTEG,
    ST_KP,
    ST_KI_LO,
    ST_KI_HI,
    ST_FINISH
  } ctrl_state_t;

  // Datapath operations, one per cycle
  typedef enum logic [3:0] {
    OP_NONE,
    OP_SPEED,
    OP_RAW,
    OP_FILT_NEW,
    OP_FILT_OLD,
    OP_FILT_SUM,
    OP_ERR,
    OP_INTEG,
    OP_KP,
    OP_KI_LO,
    OP_KI_HI,
    OP_FINISH
  } dp_op_t;

  typedef struct packed {
    logic   take;
    dp_op_t op;
  } dp_cmd_t;

endpackage

`default_nettype wire

[rtl/core/espc_if.sv]
// ----------------------------------------------------------------------------
// espc channel interfaces
// Sample, result and configuration channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
`default_nettype none

interface espc_sample_if;
  import espc_pkg::*;
  logic                       valid;
  logic                       ready;
  logic signed [PULSE_W-1:0]  pulse_delta;
  logic signed [TARGET_W-1:0] target_rpm;

  modport source (output valid, output pulse_delta, output target_rpm, input ready);
  modport sink   (input valid, input pulse_delta, input target_rpm, output ready);
endinterface

interface espc_result_if;
  import espc_pkg::*;
  logic                      valid;
  logic                      ready;
  logic signed [DRIVE_W-1:0] drive_value;
  logic signed [SPEED_W-1:0] speed_estimate;
  logic                      clamped;

  modport source (output valid, output drive_value, output speed_estimate,
                  output clamped, input ready);
  modport sink   (input valid, input drive_value, input speed_estimate,
                  input clamped, output ready);
endinterface

interface espc_cfg_if;
  import espc_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

[rtl/core/espc_regs.sv]
// ----------------------------------------------------------------------------
// espc_regs
// Configuration register file, written through the configuration channel.
// ----------------------------------------------------------------------------
`default_nettype none

module espc_regs (
  input  logic           clk,
  input  logic           rst,
  espc_cfg_if.sink       cfg,
  output espc_pkg::cfg_t regs
);
  import espc_pkg::*;

  // Always take a write request
  assign cfg.ready = 1'b1;

  // Decode the index and update one register; unknown indexes drop the write
  always_ff @(posedge clk) begin
    if (rst) begin
      regs.dir   <= 1'b0;
      regs.rpp   <= 16'd16;
      regs.alpha <= 17'd13107;
      regs.kp    <= 16'd256;
      regs.ki    <= 16'd655;
      regs.limit <= 15'd1000;
      regs.ramp  <= 15'd10;
    end else if (cfg.valid) begin
      case (cfg_idx_t'(cfg.index))
        REG_DIR:   regs.dir   <= cfg.data[0];
        REG_RPP:   regs.rpp   <= cfg.data[15:0];
        REG_ALPHA: regs.alpha <= cfg.data[16:0];
        REG_KP:    regs.kp    <= cfg.data[15:0];
        REG_KI:    regs.ki    <= cfg.data[15:0];
        REG_LIMIT: regs.limit <= cfg.data[14:0];
        REG_RAMP:  regs.ramp  <= cfg.data[14:0];
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

[rtl/core/espc_ctrl.sv]
// ----------------------------------------------------------------------------
// espc_ctrl
// Sequencer: steps the datapath through one sample and owns result valid.
// ----------------------------------------------------------------------------
`default_nettype none

module espc_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output espc_pkg::dp_cmd_t cmd
);
  import espc_pkg::*;

  ctrl_state_t state;
  ctrl_state_t state_next;
  logic        can_publish;
  logic        publish;

  assign can_publish = !out_valid || out_ready;

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:     if (in_valid) state_next = ST_SPEED;
      ST_SPEED:    state_next = ST_RAW;
      ST_RAW:      state_next = ST_FILT_NEW;
      ST_FILT_NEW: state_next = ST_FILT_OLD;
      ST_FILT_OLD: state_next = ST_FILT_SUM;
      ST_FILT_SUM: state_next = ST_ERR;
      ST_ERR:      state_next = ST_INTEG;
      ST_INTEG:    state_next = ST_KP;
      ST_KP:       state_next = ST_KI_LO;
      ST_KI_LO:    state_next = ST_KI_HI;
      ST_KI_HI:    state_next = ST_FINISH;
      ST_FINISH:   if (can_publish) state_next = ST_IDLE;
      default:     state_next = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    in_ready = 1'b0;
    cmd.take = 1'b0;
    cmd.op   = OP_NONE;
    publish  = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.take = in_valid;
      end
      ST_SPEED:    cmd.op = OP_SPEED;
      ST_RAW:      cmd.op = OP_RAW;
      ST_FILT_NEW: cmd.op = OP_FILT_NEW;
      ST_FILT_OLD: cmd.op = OP_FILT_OLD;
      ST_FILT_SUM: cmd.op = OP_FILT_SUM;
      ST_ERR:      cmd.op = OP_ERR;
      ST_INTEG:    cmd.op = OP_INTEG;
      ST_KP:       cmd.op = OP_KP;
      ST_KI_LO:    cmd.op = OP_KI_LO;
      ST_KI_HI:    cmd.op = OP_KI_HI;
      ST_FINISH: begin
        if (can_publish) begin
          cmd.op  = OP_FINISH;
          publish = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // State and result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (publish) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

[rtl/core/espc_dp.sv]
// ----------------------------------------------------------------------------
// espc_dp
// Datapath: shared multiplier, speed filter, ramp, saturating integral, clamp.
// ----------------------------------------------------------------------------
`default_nettype none

module espc_dp (
  input  logic                                  clk,
  input  logic                                  rst,
  input  espc_pkg::cfg_t                        regs,
  input  espc_pkg::dp_cmd_t                     cmd,
  input  logic signed [espc_pkg::PULSE_W-1:0]   pulse_delta,
  input  logic signed [espc_pkg::TARGET_W-1:0]  target_rpm,
  output logic signed [espc_pkg::DRIVE_W-1:0]   drive_value,
  output logic signed [espc_pkg::SPEED_W-1:0]   speed_estimate,
  output logic                                  clamped
);
  import espc_pkg::*;

  // Held sample
  logic signed [PULSE_W-1:0]  pd_q;
  logic signed [TARGET_W-1:0] tgt_q;

  // Controller state of the loop
  logic signed [SPEED_W-1:0]        smoothed;
  logic signed [TARGET_W-1:0]       setpoint;
  logic signed [INTEGRAL_WIDTH-1:0] integral;

  // Work registers
  logic signed [INTEGRAL_WIDTH-1:0] prev_integral;
  logic signed [PROD_W-1:0]         prod;
  logic signed [PROD_W-1:0]         acc;
  logic signed [SPEED_W-1:0]        raw;
  logic signed [ERR_W-1:0]          err;
  logic signed [TOTAL_W-1:0]        total;

  // Multiplier operands
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;

  logic [16:0] alpha_c;

  // Raw speed
  logic signed [32:0] speed_p;
  logic signed [32:0] speed_dir;
  logic signed [36:0] speed_x16;
  logic signed [SPEED_W-1:0] raw_next;

  // Filter sum
  logic signed [PROD_W-1:0] filt_sum;

  // Ramp
  logic signed [17:0]         sp_x;
  logic signed [17:0]         tgt_x;
  logic signed [17:0]         step_x;
  logic signed [17:0]         ramp_up;
  logic signed [17:0]         ramp_dn;
  logic signed [TARGET_W-1:0] setpoint_next;

  // Integral
  logic signed [INTEGRAL_WIDTH:0]   integ_sum;
  logic signed [INTEGRAL_WIDTH-1:0] integral_next;
  logic signed [OPX_W-1:0]          integ_x;
  logic signed [OPX_W-1:0]          op_x;
  logic signed [OP_W-1:0]           op;
  logic signed [OP_HI_W-1:0]        op_hi;
  logic [23:0]                      op_lo;

  // Output decision
  logic signed [TOTAL_W-1:0] lim24;
  logic signed [TOTAL_W-1:0] neg_lim24;
  logic signed [TOTAL_W-1:0] total_rnd;
  logic signed [TOTAL_W-1:0] total_trunc;

  assign alpha_c = (regs.alpha > ALPHA_ONE) ? ALPHA_ONE : regs.alpha;

  // Clamp the integral to the multiplier operand range and split it
  assign integ_x = OPX_W'(integral);
  assign op_x    = (integ_x > OP_MAX_X) ? OP_MAX_X :
                   (integ_x < OP_MIN_X) ? OP_MIN_X : integ_x;
  assign op      = op_x[OP_W-1:0];
  assign op_hi   = signed'(op[OP_W-1:24]);
  assign op_lo   = op[23:0];

  // Select multiplier operands for this step
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.op)
      OP_SPEED: begin
        mul_a = signed'(MUL_A_W'(regs.rpp));
        mul_b = MUL_B_W'(pd_q);
      end
      OP_FILT_NEW: begin
        mul_a = signed'(MUL_A_W'(alpha_c));
        mul_b = MUL_B_W'(raw);
      end
      OP_FILT_OLD: begin
        mul_a = signed'(MUL_A_W'(ALPHA_ONE - alpha_c));
        mul_b = MUL_B_W'(smoothed);
      end
      OP_INTEG: begin
        mul_a = signed'(MUL_A_W'(regs.kp));
        mul_b = MUL_B_W'(err);
      end
      OP_KP: begin
        mul_a = signed'(MUL_A_W'(regs.ki));
        mul_b = signed'(MUL_B_W'(op_lo));
      end
      OP_KI_LO: begin
        mul_a = signed'(MUL_A_W'(regs.ki));
        mul_b = MUL_B_W'(op_hi);
      end
      default: begin
      end
    endcase
  end

  // Measured speed: sign by direction, scale to Q16.8, saturate
  assign speed_p   = prod[32:0];
  assign speed_dir = regs.dir ? -speed_p : speed_p;
  assign speed_x16 = 37'(speed_dir) <<< 4;
  assign raw_next  = (speed_x16 > SPD_MAX_X) ? SPD_MAX_X[SPEED_W-1:0] :
                     (speed_x16 < SPD_MIN_X) ? SPD_MIN_X[SPEED_W-1:0] :
                     speed_x16[SPEED_W-1:0];

  assign filt_sum = acc + prod;

  // Move the setpoint toward the target, stopping on it
  assign sp_x    = 18'(setpoint);
  assign tgt_x   = 18'(tgt_q);
  assign step_x  = signed'(18'(regs.ramp));
  assign ramp_up = sp_x + step_x;
  assign ramp_dn = sp_x - step_x;

  always_comb begin
    setpoint_next = setpoint;
    if (sp_x < tgt_x) begin
      setpoint_next = (ramp_up > tgt_x) ? tgt_q : ramp_up[TARGET_W-1:0];
    end else if (sp_x > tgt_x) begin
      setpoint_next = (ramp_dn < tgt_x) ? tgt_q : ramp_dn[TARGET_W-1:0];
    end
  end

  // Saturating integral step
  assign integ_sum = (INTEGRAL_WIDTH + 1)'(integral) + (INTEGRAL_WIDTH + 1)'(err);
  assign integral_next =
    (integ_sum > INTEG_MAX_X) ? INTEG_MAX_X[INTEGRAL_WIDTH-1:0] :
    (integ_sum < INTEG_MIN_X) ? INTEG_MIN_X[INTEGRAL_WIDTH-1:0] :
    integ_sum[INTEGRAL_WIDTH-1:0];

  // Limit compare and truncation toward zero
  assign lim24       = signed'(TOTAL_W'({regs.limit, 24'd0}));
  assign neg_lim24   = -lim24;
  assign total_rnd   = total + (total[TOTAL_W-1] ? signed'(TOTAL_W'(24'hFFFFFF))
                                                 : signed'(TOTAL_W'(0)));
  assign total_trunc = total_rnd >>> 24;

  // Multiplier output register
  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  // Loop state: filter, ramp, integral
  always_ff @(posedge clk) begin
    if (rst) begin
      smoothed <= '0;
      setpoint <= '0;
      integral <= '0;
    end else begin
      case (cmd.op)
        OP_SPEED:    setpoint <= setpoint_next;
        OP_FILT_SUM: smoothed <= filt_sum[SPEED_W+15:16];
        OP_INTEG:    integral <= integral_next;
        OP_FINISH: begin
          if (total > lim24 || total < neg_lim24) begin
            integral <= prev_integral;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Work registers and result payload
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      pd_q  <= pulse_delta;
      tgt_q <= target_rpm;
    end
    case (cmd.op)
      OP_RAW:      raw <= raw_next;
      OP_FILT_OLD: acc <= prod + PROD_W'(32768);
      OP_ERR:      err <= ERR_W'(signed'({setpoint, 8'd0})) - ERR_W'(smoothed);
      OP_INTEG:    prev_integral <= integral;
      OP_KP:       total <= TOTAL_W'(prod) <<< 8;
      OP_KI_LO:    total <= total + TOTAL_W'(prod);
      OP_KI_HI:    total <= total + (TOTAL_W'(prod) <<< 24);
      OP_FINISH: begin
        speed_estimate <= smoothed;
        if (total > lim24) begin
          drive_value <= signed'(DRIVE_W'(regs.limit));
          clamped     <= 1'b1;
        end else if (total < neg_lim24) begin
          drive_value <= -signed'(DRIVE_W'(regs.limit));
          clamped     <= 1'b1;
        end else begin
          drive_value <= total_trunc[DRIVE_W-1:0];
          clamped     <= 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

[rtl/core/encoder_speed_pi_controller.sv]
// ----------------------------------------------------------------------------
// encoder_speed_pi_controller
// Encoder speed estimate, IIR smoothing, ramped setpoint and PI drive output.
// ----------------------------------------------------------------------------
//
//   channel  direction  payload                                 handshake
//   sample   in         pulse_delta, target_rpm                 valid/ready
//   result   out        drive_value, speed_estimate, clamped    valid/ready
//   cfg      in         index, data                             valid/ready
//
// A sample accepted at one clock edge gives a valid result after ten sequencer
// steps and one to publish. The next sample is taken only in the idle state,
// once the sequencer is through with the last. One 18x26 multiplier is
// shared by the speed scale, both filter taps, Kp and the two halves of Ki.
// Reset clears the loop state and loads the register defaults.
// A stalled result holds the sequencer in its last step; the next sample is
// taken while the previous result still waits. cfg is always ready.
// ----------------------------------------------------------------------------
`default_nettype none

module encoder_speed_pi_controller (
  input  logic       clk,
  input  logic       rst,
  espc_sample_if.sink   sample,
  espc_result_if.source result,
  espc_cfg_if.sink      cfg
);
  import espc_pkg::*;

  cfg_t    regs;
  dp_cmd_t cmd;

  // Register file
  espc_regs u_regs (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  // Sequencer
  espc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (sample.valid),
    .in_ready  (sample.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .cmd       (cmd)
  );

  // Datapath
  espc_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .regs           (regs),
    .cmd            (cmd),
    .pulse_delta    (sample.pulse_delta),
    .target_rpm     (sample.target_rpm),
    .drive_value    (result.drive_value),
    .speed_estimate (result.speed_estimate),
    .clamped        (result.clamped)
  );

endmodule

`default_nettype wire

[rtl/core/encoder_speed_pi_controller_checker.sv]
// ----------------------------------------------------------------------------
// encoder_speed_pi_controller_checker
// Port-level checks on the controller, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "encoder_speed_pi_controller_assert.svh"

module encoder_speed_pi_controller_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                sample_valid,
  input logic                                sample_ready,
  input logic                                result_valid,
  input logic                                result_ready,
  input logic signed [espc_pkg::DRIVE_W-1:0] drive_value,
  input logic signed [espc_pkg::SPEED_W-1:0] speed_estimate,
  input logic                                clamped
);
  import espc_pkg::*;

  logic [DRIVE_W+SPEED_W:0] payload;

  assign payload = {drive_value, speed_estimate, clamped};

  // Hold a stalled result
  `ESPC_ASSERT_NEXT(a_hold_valid, clk, rst, result_valid && !result_ready, result_valid)
  `ESPC_ASSERT_NEXT(a_hold_payload, clk, rst, result_valid && !result_ready, $stable(payload))

  // One request in work at a time
  `ESPC_ASSERT_NEXT(a_one_in_work, clk, rst, sample_valid && sample_ready, !sample_ready)

  // A new result only comes out of a busy sequencer
  `ESPC_ASSERT_IMPLY(a_result_from_work, clk, rst, $rose(result_valid), !$past(sample_ready))

  // Drive never reaches the most negative code
  `ESPC_ASSERT_IMPLY(a_drive_range, clk, rst, result_valid, drive_value != 16'sh8000)

endmodule

bind encoder_speed_pi_controller encoder_speed_pi_controller_checker u_checker (
  .clk            (clk),
  .rst            (rst),
  .sample_valid   (sample.valid),
  .sample_ready   (sample.ready),
  .result_valid   (result.valid),
  .result_ready   (result.ready),
  .drive_value    (result.drive_value),
  .speed_estimate (result.speed_estimate),
  .clamped        (result.clamped)
);

`default_nettype wire
